// ===== hdl/kpd_pkg.sv =====
// ---------------------------------------------------------------------------
// kpd_pkg: shared types and constants of the key press detector
// Event codes, register indexes, register reset values and field widths.
// ---------------------------------------------------------------------------
`default_nettype none

package kpd_pkg;

  localparam int unsigned PressW   = 16;
  localparam int unsigned ReleaseW = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  // Release must stay stable for more ticks than this before it counts
  localparam logic [ReleaseW-1:0] ReleaseStableTicks = ReleaseW'(50);

  localparam logic [PressW-1:0]   ShortThresholdRst   = PressW'(50);
  localparam logic [PressW-1:0]   LongThresholdRst    = PressW'(1000);
  localparam logic [PressW-1:0]   PressTimeLimitRst   = PressW'(3000);
  localparam logic [ReleaseW-1:0] ReleaseTimeLimitRst = ReleaseW'(255);

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvShort = 2'd1,
    EvLong  = 2'd2
  } press_event_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegShortThreshold   = 2'd0,
    RegLongThreshold    = 2'd1,
    RegPressTimeLimit   = 2'd2,
    RegReleaseTimeLimit = 2'd3
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== hdl/key_short_long_press_detector.sv =====
// ---------------------------------------------------------------------------
// key_short_long_press_detector: short and long key press detection
// Tracks press and release timers from tick and scan words and reports a
// short or long press event in its result word with the held and hold marks.
// ---------------------------------------------------------------------------
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, action_i,        | input word
//           | key_level_i                              |
//   out     | out_valid_o, out_ready_i, press_event_o, | result word
//           | key_held_o, radio_hold_o                 |
//   cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i         | register write
//
// One word per cycle unless a stalled result blocks the input; each result is
// loaded into the output register in the cycle after its word is accepted.
// The whole state update (two saturating counters, three compares and the
// flag logic) fits between the state registers and the output register.
// Reset clears all state marks and timers and loads the register
// defaults; there is no clearing pass.
// A stalled result holds in the output register; a new word is taken in the
// same cycle the held result leaves.
// ---------------------------------------------------------------------------
`default_nettype none

module key_short_long_press_detector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic                           key_level_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     press_event_o,
  output logic                           key_held_o,
  output logic                           radio_hold_o,
  // register writes
  input  logic                           cfg_we_i,
  input  logic [kpd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [kpd_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  localparam int unsigned PW = kpd_pkg::PressW;
  localparam int unsigned RW = kpd_pkg::ReleaseW;

  // Configuration registers
  logic [PW-1:0] short_thr_q, long_thr_q, press_lim_q;
  logic [RW-1:0] release_lim_q;

  // Detector state
  logic          pressed_q, pressed_d;
  logic          released_q, released_d;
  logic [PW-1:0] press_ticks_q, press_ticks_d;
  logic [RW-1:0] release_ticks_q, release_ticks_d;
  logic          short_armed_q, short_armed_d;
  logic          long_fired_q, long_fired_d;
  logic          hold_q, hold_d;

  // Output register
  logic          out_valid_q;
  logic [1:0]    press_event_q;
  logic          key_held_q;
  logic          radio_hold_q;

  logic          in_accept;
  kpd_pkg::press_event_e event_d;

  // Saturating increments; the extra bit catches the wrap at full scale
  logic [PW:0]   press_inc;
  logic [RW:0]   release_inc;
  logic [PW-1:0] press_sat;
  logic [RW-1:0] release_sat;

  // Take a word whenever the output register is empty or drains this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_thr_q   <= kpd_pkg::ShortThresholdRst;
      long_thr_q    <= kpd_pkg::LongThresholdRst;
      press_lim_q   <= kpd_pkg::PressTimeLimitRst;
      release_lim_q <= kpd_pkg::ReleaseTimeLimitRst;
    end else if (cfg_we_i) begin
      unique case (kpd_pkg::cfg_reg_e'(cfg_idx_i))
        kpd_pkg::RegShortThreshold:   short_thr_q   <= cfg_wdata_i[PW-1:0];
        kpd_pkg::RegLongThreshold:    long_thr_q    <= cfg_wdata_i[PW-1:0];
        kpd_pkg::RegPressTimeLimit:   press_lim_q   <= cfg_wdata_i[PW-1:0];
        kpd_pkg::RegReleaseTimeLimit: release_lim_q <= cfg_wdata_i[RW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Next state and event
  // ---------------------------------------------------------------------
  assign press_inc   = {1'b0, press_ticks_q} + (PW+1)'(1);
  assign release_inc = {1'b0, release_ticks_q} + (RW+1)'(1);
  // Clamp to the limit, also when the timer already sits above a new limit
  assign press_sat   = (press_inc >= {1'b0, press_lim_q}) ? press_lim_q
                                                          : press_inc[PW-1:0];
  assign release_sat = (release_inc >= {1'b0, release_lim_q}) ? release_lim_q
                                                              : release_inc[RW-1:0];

  always_comb begin
    pressed_d       = pressed_q;
    released_d      = released_q;
    press_ticks_d   = press_ticks_q;
    release_ticks_d = release_ticks_q;
    short_armed_d   = short_armed_q;
    long_fired_d    = long_fired_q;
    hold_d          = hold_q;
    event_d         = kpd_pkg::EvNone;

    if (!action_i) begin
      // Tick: advance each timer while its mark is set
      if (pressed_q) begin
        press_ticks_d = press_sat;
      end
      if (released_q) begin
        release_ticks_d = release_sat;
      end
    end else if (key_level_i) begin
      if (!pressed_q) begin
        // Fresh press: restart both timers and all flags
        hold_d          = 1'b1;
        released_d      = 1'b0;
        pressed_d       = 1'b1;
        press_ticks_d   = '0;
        release_ticks_d = '0;
        short_armed_d   = 1'b0;
        long_fired_d    = 1'b0;
      end else begin
        // Still pressed (or pressed again before a stable release)
        if (press_ticks_q > short_thr_q && !short_armed_q) begin
          short_armed_d = 1'b1;
        end
        if (press_ticks_q > long_thr_q && !long_fired_q) begin
          long_fired_d = 1'b1;
          event_d      = kpd_pkg::EvLong;
        end
      end
    end else begin
      if (!released_q) begin
        // First release scan: start the release timer
        released_d      = 1'b1;
        release_ticks_d = '0;
      end else if (release_ticks_q > kpd_pkg::ReleaseStableTicks) begin
        // Release is stable: drop the press and report a short one if due
        pressed_d = 1'b0;
        hold_d    = 1'b0;
        if (short_armed_q && !long_fired_q) begin
          short_armed_d = 1'b0;
          event_d       = kpd_pkg::EvShort;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // State registers: advance only on an accepted word
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q       <= 1'b0;
      released_q      <= 1'b0;
      press_ticks_q   <= '0;
      release_ticks_q <= '0;
      short_armed_q   <= 1'b0;
      long_fired_q    <= 1'b0;
      hold_q          <= 1'b0;
    end else if (in_accept) begin
      pressed_q       <= pressed_d;
      released_q      <= released_d;
      press_ticks_q   <= press_ticks_d;
      release_ticks_q <= release_ticks_d;
      short_armed_q   <= short_armed_d;
      long_fired_q    <= long_fired_d;
      hold_q          <= hold_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: load on accept, drop once taken, hold while stalled
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      press_event_q <= event_d;
      key_held_q    <= pressed_d;
      radio_hold_q  <= hold_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign press_event_o = press_event_q;
  assign key_held_o    = key_held_q;
  assign radio_hold_o  = radio_hold_q;

endmodule

`default_nettype wire

// ===== hdl/kpd_checker.sv =====
// ---------------------------------------------------------------------------
// kpd_checker: port-level checks for the key press detector
// Watches the ports of the top level and flags illegal result words.
// ---------------------------------------------------------------------------
`default_nettype none

module kpd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [1:0]                   press_event_o,
  input logic                         key_held_o,
  input logic                         radio_hold_o
);

  // A stalled result word holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(press_event_o) && $stable(key_held_o)
      && $stable(radio_hold_o))
    else $error("stalled result word changed");

  // An empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output register");

  // Held and hold marks are set and cleared together
  a_marks_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> key_held_o == radio_hold_o)
    else $error("key_held and radio_hold disagree");

  // A long press fires while the key is still held
  a_long_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && press_event_o == kpd_pkg::EvLong |-> key_held_o)
    else $error("long press reported without held key");

  // A short press fires only on the stable release
  a_short_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && press_event_o == kpd_pkg::EvShort |-> !key_held_o && !radio_hold_o)
    else $error("short press reported while key held");

endmodule

bind key_short_long_press_detector kpd_checker u_kpd_checker (.*);

`default_nettype wire

// ===== test/key_press_compare.sv =====
// ---------------------------------------------------------------------------
// key_press_compare: result prediction and comparison for the press detector
// Follows register writes and accepted input words, predicts one result word
// per input word and compares each accepted result word field by field.
// ---------------------------------------------------------------------------
module key_press_compare
  import kpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                action_i,
  input  logic                key_level_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [1:0]          press_event_i,
  input  logic                key_held_i,
  input  logic                radio_hold_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  pending_o,
  output int                  fails_o
);

  typedef struct packed {
    press_event_e ev;
    logic         held;
    logic         hold;
  } key_word_t;

  logic [PressW-1:0]   short_thr, long_thr, press_lim;
  logic [ReleaseW-1:0] rel_lim;
  logic                pressed, released, armed, long_done, hold;
  logic [PressW-1:0]   press_cnt;
  logic [ReleaseW-1:0] rel_cnt;
  key_word_t           want_q[$];
  int                  fail_cnt;

  function automatic logic [PressW-1:0] sat_inc(logic [PressW-1:0] v,
                                                logic [PressW-1:0] lim);
    logic [PressW:0] n;
    n = {1'b0, v} + 1'b1;
    return (n >= {1'b0, lim}) ? lim : n[PressW-1:0];
  endfunction

  // Advance the key state by one word and return the result it causes
  function automatic key_word_t predict_word(logic scan, logic level);
    key_word_t w;
    w.ev = EvNone;
    if (!scan) begin
      if (pressed) press_cnt = sat_inc(press_cnt, press_lim);
      if (released) rel_cnt = ReleaseW'(sat_inc(PressW'(rel_cnt), PressW'(rel_lim)));
    end else if (level) begin
      if (!pressed) begin
        hold      = 1'b1;
        released  = 1'b0;
        pressed   = 1'b1;
        press_cnt = '0;
        rel_cnt   = '0;
        armed     = 1'b0;
        long_done = 1'b0;
      end else begin
        if (press_cnt > short_thr) armed = 1'b1;
        if (press_cnt > long_thr && !long_done) begin
          long_done = 1'b1;
          w.ev      = EvLong;
        end
      end
    end else if (!released) begin
      released = 1'b1;
      rel_cnt  = '0;
    end else if (rel_cnt > ReleaseStableTicks) begin
      pressed = 1'b0;
      hold    = 1'b0;
      if (armed && !long_done) begin
        armed = 1'b0;
        w.ev  = EvShort;
      end
    end
    w.held = pressed;
    w.hold = hold;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    key_word_t want;
    if (!rst_ni) begin
      short_thr = ShortThresholdRst;
      long_thr  = LongThresholdRst;
      press_lim = PressTimeLimitRst;
      rel_lim   = ReleaseTimeLimitRst;
      pressed   = 1'b0;
      released  = 1'b0;
      armed     = 1'b0;
      long_done = 1'b0;
      hold      = 1'b0;
      press_cnt = '0;
      rel_cnt   = '0;
      fail_cnt  = 0;
      want_q.delete();
      pending_o <= 0;
      fails_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          RegShortThreshold:   short_thr = cfg_wdata_i;
          RegLongThreshold:    long_thr  = cfg_wdata_i;
          RegPressTimeLimit:   press_lim = cfg_wdata_i;
          RegReleaseTimeLimit: rel_lim   = cfg_wdata_i[ReleaseW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (want_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("key_press_compare: %0t: result word with none expected", $time);
          fail_cnt++;
        end else begin
          want = want_q.pop_front();
          if (want.ev !== press_event_i || want.held !== key_held_i ||
              want.hold !== radio_hold_i) begin
            if (fail_cnt < 10)
              $display({"key_press_compare: %0t: event exp %0d got %0d, ",
                        "held exp %0b got %0b, hold exp %0b got %0b"},
                       $time, want.ev, press_event_i, want.held, key_held_i,
                       want.hold, radio_hold_i);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i) want_q.push_back(predict_word(action_i, key_level_i));
      pending_o <= want_q.size();
      fails_o   <= fail_cnt;
    end
  end

endmodule

// ===== test/tb_key_short_long_press_detector.sv =====
// ---------------------------------------------------------------------------
// tb_key_short_long_press_detector: stimulus and verdict for the detector
// Drives tick and scan words through several register settings with random
// gaps and stalls on both channels; key_press_compare checks every result.
// ---------------------------------------------------------------------------
module tb_key_short_long_press_detector;
  import kpd_pkg::*;

  // Word kinds on the action field
  localparam logic ActTick = 1'b0;
  localparam logic ActScan = 1'b1;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid, in_ready, action, key_level;
  logic                out_valid, out_ready;
  logic [1:0]          press_event;
  logic                key_held, radio_hold;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  int                  pending, fails;

  // Idle percentages of sender and receiver, word count, long stall request
  int                  snd_idle, rcv_idle;
  int                  sent;
  bit                  hold_off;

  key_short_long_press_detector uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .key_level_i   (key_level),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .press_event_o (press_event),
    .key_held_o    (key_held),
    .radio_hold_o  (radio_hold),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  key_press_compare u_compare (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .action_i      (action),
    .key_level_i   (key_level),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .press_event_i (press_event),
    .key_held_i    (key_held),
    .radio_hold_i  (radio_hold),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .pending_o     (pending),
    .fails_o       (fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one word, idling first at random; return once it is taken.
  // Valid stays high into the next word when no gap is drawn.
  task automatic push_word(logic act, logic lvl);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    action    <= act;
    key_level <= lvl;
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  // Drop valid, drain every expected result, then allow for the output stage
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all four registers on back-to-back edges while the block is idle
  task automatic set_regs(logic [15:0] short_v, logic [15:0] long_v,
                          logic [15:0] press_v, logic [15:0] rel_v);
    cfg_we    <= 1'b1;
    cfg_idx   <= RegShortThreshold;
    cfg_wdata <= short_v;
    @(posedge clk_i);
    cfg_idx   <= RegLongThreshold;
    cfg_wdata <= long_v;
    @(posedge clk_i);
    cfg_idx   <= RegPressTimeLimit;
    cfg_wdata <= press_v;
    @(posedge clk_i);
    cfg_idx   <= RegReleaseTimeLimit;
    cfg_wdata <= rel_v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // One press: scan pressed, ticks with pressed scans between them, then a
  // release that often runs past the stable point and now and then re-presses.
  task automatic press_cycle(int hold_max);
    int hold_len, rel_len;
    hold_len = $urandom_range(hold_max);
    rel_len  = ($urandom_range(4) == 0) ? $urandom_range(10) : $urandom_range(60, 45);
    push_word(ActScan, 1'b1);
    repeat (hold_len) begin
      push_word(ActTick, 1'($urandom));
      if ($urandom_range(2) == 0) push_word(ActScan, 1'b1);
    end
    push_word(ActScan, 1'b1);
    push_word(ActScan, 1'b0);
    repeat (rel_len) begin
      push_word(ActTick, 1'($urandom));
      if ($urandom_range(5) == 0) push_word(ActScan, $urandom_range(9) == 0);
    end
    push_word(ActScan, 1'b0);
  endtask

  // Mostly well-formed presses, the rest short bursts of arbitrary words
  task automatic run_random(int words, int hold_max);
    int stop;
    stop = sent + words;
    while (sent < stop) begin
      if ($urandom_range(99) < 75) begin
        press_cycle(hold_max);
      end else begin
        repeat ($urandom_range(6, 1)) push_word(1'($urandom), 1'($urandom));
      end
    end
  endtask

  // Receiver: stall at random, or hold off for a long stretch on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  initial begin
    in_valid  <= 1'b0;
    action    <= ActTick;
    key_level <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= RegShortThreshold;
    cfg_wdata <= '0;
    rst_ni    <= 1'b0;
    snd_idle  = 37;
    rcv_idle  = 46;
    sent      = 0;
    hold_off  = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: idle tick, lone release, press and a held scan
    push_word(ActTick, 1'b0);
    push_word(ActScan, 1'b0);
    push_word(ActScan, 1'b1);
    push_word(ActTick, 1'b1);
    push_word(ActScan, 1'b1);
    drain();

    // Tiny thresholds so every step of a press shows within a few words
    set_regs(16'd1, 16'd3, 16'd5, 16'd60);
    push_word(ActTick, 1'b0);
    push_word(ActScan, 1'b0);   // first release scan of the held press
    push_word(ActTick, 1'b1);
    push_word(ActScan, 1'b0);
    push_word(ActTick, 1'b0);
    push_word(ActScan, 1'b1);   // still held from before: no fresh start
    push_word(ActTick, 1'b0);
    push_word(ActTick, 1'b0);
    push_word(ActScan, 1'b1);   // still above short and long: long already fired
    push_word(ActScan, 1'b1);   // long fires only once
    push_word(ActTick, 1'b0);
    push_word(ActTick, 1'b1);
    push_word(ActTick, 1'b0);   // press timer at its limit
    push_word(ActTick, 1'b0);
    push_word(ActScan, 1'b0);
    push_word(ActTick, 1'b0);
    push_word(ActScan, 1'b1);   // re-press before the release is stable
    push_word(ActTick, 1'b0);
    push_word(ActScan, 1'b0);   // release again: release timer keeps running
    push_word(ActTick, 1'b0);
    drain();

    // Lower the press limit under the held timer; first word is a tick
    set_regs(16'd0, 16'd1, 16'd3, 16'hFFFF);
    push_word(ActTick, 1'b0);
    run_random(100, 6);
    drain();

    // Swap the idle rates; thresholds and limit at the top of the range
    snd_idle = 46;
    rcv_idle = 37;
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0033);
    run_random(60, 8);
    drain();

    // Press limit of zero and a release limit that never reaches stable
    set_regs(16'd3, 16'd10, 16'h0000, 16'h0001);
    run_random(40, 14);
    drain();

    // No idling; stall the receiver long enough to back up the input
    snd_idle = 0;
    rcv_idle = 0;
    set_regs(16'd2, 16'd8, 16'd12, 16'h0050);
    push_word(ActScan, 1'b1);
    hold_off = 1'b1;
    run_random(80, 14);
    drain();

    if (fails == 0) begin
      $display("tb_key_short_long_press_detector: done, clean");
    end else begin
      $display("tb_key_short_long_press_detector: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #400000;
    $display("tb_key_short_long_press_detector: done, errors");
    $finish;
  end

endmodule
